// ===== src/tnsg_pkg.sv =====
// shared types, constants and helper functions for the three-tone sound generator
// used by tnsg_ctrl, tnsg_dp and the top level; no dependencies
package tnsg_pkg;

    // input item kinds (carried on s_tuser)
    localparam logic [2:0] MODE_LATCH = 3'd0;
    localparam logic [2:0] MODE_WRITE = 3'd1;
    localparam logic [2:0] MODE_READ  = 3'd2;
    localparam logic [2:0] MODE_START = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    // register map
    localparam logic [3:0] REG_NOISE      = 4'd6;
    localparam logic [3:0] REG_ENABLE     = 4'd7;
    localparam logic [3:0] REG_VOL_A      = 4'd8;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_SHAPE      = 4'd13;

    // fixed tuning
    localparam int PERIOD_SCALE  = 1;
    localparam int ENV_DECREMENT = 2;
    localparam int PARK_LIMIT    = 2;
    localparam logic [17:0] LFSR_TAPS = 18'h24000;

    // divide by 3 * ENV_DECREMENT * 256 as (sum >> 9) * 683 >> 11
    localparam int SCALE_RECIP = 683;
    localparam int SCALE_SHIFT = 11;

    // controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       exec;
        logic       noise;
        logic       env;
        logic       mac;
        logic [1:0] mac_ch;
        logic       scale;
        logic       sub_init;
        logic       load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic in_tick;
        logic left_last;
    } sts_t;

    // logarithmic output level table
    function automatic logic [15:0] level(input logic [4:0] idx);
        logic [15:0] v;
        v = 16'd0;
        case (idx)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd184;
            5'd2:  v = 16'd219;
            5'd3:  v = 16'd260;
            5'd4:  v = 16'd309;
            5'd5:  v = 16'd368;
            5'd6:  v = 16'd437;
            5'd7:  v = 16'd519;
            5'd8:  v = 16'd617;
            5'd9:  v = 16'd734;
            5'd10: v = 16'd872;
            5'd11: v = 16'd1036;
            5'd12: v = 16'd1232;
            5'd13: v = 16'd1464;
            5'd14: v = 16'd1740;
            5'd15: v = 16'd2067;
            5'd16: v = 16'd2457;
            5'd17: v = 16'd2920;
            5'd18: v = 16'd3471;
            5'd19: v = 16'd4125;
            5'd20: v = 16'd4903;
            5'd21: v = 16'd5827;
            5'd22: v = 16'd6925;
            5'd23: v = 16'd8231;
            5'd24: v = 16'd9782;
            5'd25: v = 16'd11626;
            5'd26: v = 16'd13818;
            5'd27: v = 16'd16422;
            5'd28: v = 16'd19518;
            5'd29: v = 16'd23197;
            5'd30: v = 16'd27570;
            5'd31: v = 16'd32767;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // raw register period to counter period, zero acts as one
    function automatic logic [16:0] scale_period(input logic [15:0] raw);
        logic [20:0] m;
        m = 21'(raw) * 21'(PERIOD_SCALE);
        if (raw == 16'd0) begin
            m = 21'(PERIOD_SCALE);
        end
        return m[16:0];
    endfunction

    // shift a running count by the change of period, never below one
    function automatic logic signed [18:0] retune(input logic signed [18:0] cnt,
                                                  input logic [16:0] p_new,
                                                  input logic [16:0] p_old);
        logic signed [18:0] t;
        t = cnt + $signed({2'b00, p_new}) - $signed({2'b00, p_old});
        if (t <= 19'sd0) begin
            t = 19'sd1;
        end
        return t;
    endfunction

endpackage

// ===== src/tnsg_ctrl.sv =====
// sequencing state machine of the sound generator
// depends on tnsg_pkg (command and status types)
module tnsg_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output tnsg_pkg::cmd_t  cmd,
    input  tnsg_pkg::sts_t  sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_NOISE = 3'd2;
    localparam logic [2:0] ST_ENV   = 3'd3;
    localparam logic [2:0] ST_MAC   = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       sub_reg, sub_next;
    logic [1:0] mac_ch_reg, mac_ch_next;
    logic       out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        sub_next    = sub_reg;
        mac_ch_next = mac_ch_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    sub_next   = 1'b0;
                    state_next = sts.in_tick ? ST_NOISE : ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_NOISE: begin
                cmd.noise = 1'b1;
                if (sts.left_last) begin
                    state_next = ST_ENV;
                end
            end
            ST_ENV: begin
                cmd.env     = 1'b1;
                mac_ch_next = 2'd0;
                state_next  = sub_reg ? ST_DONE : ST_MAC;
            end
            ST_MAC: begin
                cmd.mac    = 1'b1;
                cmd.mac_ch = mac_ch_reg;
                if (mac_ch_reg == 2'd2) begin
                    state_next = ST_SCALE;
                end else begin
                    mac_ch_next = mac_ch_reg + 2'd1;
                end
            end
            ST_SCALE: begin
                cmd.scale    = 1'b1;
                cmd.sub_init = 1'b1;
                sub_next     = 1'b1;
                state_next   = ST_NOISE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output beat holding
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sub_reg       <= 1'b0;
            mac_ch_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sub_reg       <= sub_next;
            mac_ch_reg    <= mac_ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/tnsg_dp.sv =====
// datapath: register file, tone, noise and envelope generators, mixer
// depends on tnsg_pkg (types, constants, level table, period helpers)
module tnsg_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      s_tdata,
    input  logic [2:0]      s_tuser,
    input  tnsg_pkg::cmd_t  cmd,
    output tnsg_pkg::sts_t  sts,
    output logic [15:0]     m_tdata,
    output logic            m_tuser
);

    // architectural state
    logic [7:0]         reg_file_reg [16];
    logic [7:0]         reg_file_next [16];
    logic [3:0]         addr_reg, addr_next;
    logic [12:0]        tone_period_reg [3];
    logic [12:0]        tone_period_next [3];
    logic signed [13:0] tone_count_reg [3];
    logic signed [13:0] tone_count_next [3];
    logic [2:0]         tone_level_reg, tone_level_next;
    logic [5:0]         noise_period_reg, noise_period_next;
    logic signed [7:0]  noise_count_reg, noise_count_next;
    logic [7:0]         noise_level_reg, noise_level_next;
    logic [7:0]         gate_mask_reg, gate_mask_next;
    logic [16:0]        lfsr_reg, lfsr_next;
    logic [16:0]        env_period_reg, env_period_next;
    logic signed [17:0] env_count_reg, env_count_next;
    logic [7:0]         env_step_reg, env_step_next;
    logic [2:0]         env_flags_reg, env_flags_next;
    logic [4:0]         env_attack_reg, env_attack_next;
    logic [15:0]        env_vol_reg, env_vol_next;
    logic [15:0]        chan_vol_reg [3];
    logic [15:0]        chan_vol_next [3];
    logic [2:0]         uses_env_reg, uses_env_next;

    // working item and sub-step payload
    logic [2:0]         item_mode_reg, item_mode_next;
    logic [7:0]         item_data_reg, item_data_next;
    logic [1:0]         left_reg, left_next;
    logic [2:0]         acc_reg [3];
    logic [2:0]         acc_next [3];
    logic [18:0]        sum_reg, sum_next;
    logic [7:0]         rd_reg, rd_next;
    logic [7:0]         smp_reg, smp_next;
    logic [15:0]        m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;

    logic               two;

    // noise iteration consumes two time units only when both are available
    assign two = (noise_count_reg != 8'sd1) && (left_reg == 2'd2);

    assign sts.in_tick   = (s_tuser == tnsg_pkg::MODE_TICK);
    assign sts.left_last = two || (left_reg == 2'd1);
    assign m_tdata       = m_data_reg;
    assign m_tuser       = m_user_reg;

    always_comb begin
        logic signed [14:0] c;
        logic signed [14:0] cp;
        logic signed [14:0] pp;
        logic signed [14:0] negc;
        logic [16:0]        per;
        logic signed [18:0] rc;
        logic [7:0]         wv;
        logic [7:0]         fine;
        logic [7:0]         coarse;
        logic [1:0]         contrib;
        logic signed [8:0]  ncp;
        logic signed [18:0] ec;
        logic signed [18:0] pe;
        logic [7:0]         st;
        logic [4:0]         att;
        logic [2:0]         flg;
        logic [15:0]        vol;
        logic [17:0]        lt;
        logic [7:0]         nl;
        logic [18:0]        prod;
        logic [19:0]        q;

        c = '0; cp = '0; pp = '0; negc = '0; per = '0; rc = '0; wv = '0;
        fine = '0; coarse = '0; contrib = '0; ncp = '0; ec = '0; pe = '0;
        st = '0; att = '0; flg = '0; vol = '0; lt = '0; nl = '0; prod = '0; q = '0;

        reg_file_next     = reg_file_reg;
        addr_next         = addr_reg;
        tone_period_next  = tone_period_reg;
        tone_count_next   = tone_count_reg;
        tone_level_next   = tone_level_reg;
        noise_period_next = noise_period_reg;
        noise_count_next  = noise_count_reg;
        noise_level_next  = noise_level_reg;
        gate_mask_next    = gate_mask_reg;
        lfsr_next         = lfsr_reg;
        env_period_next   = env_period_reg;
        env_count_next    = env_count_reg;
        env_step_next     = env_step_reg;
        env_flags_next    = env_flags_reg;
        env_attack_next   = env_attack_reg;
        env_vol_next      = env_vol_reg;
        chan_vol_next     = chan_vol_reg;
        uses_env_next     = uses_env_reg;
        item_mode_next    = item_mode_reg;
        item_data_next    = item_data_reg;
        left_next         = left_reg;
        acc_next          = acc_reg;
        sum_next          = sum_reg;
        rd_next           = rd_reg;
        smp_next          = smp_reg;
        m_data_next       = m_data_reg;
        m_user_next       = m_user_reg;

        // take a new item
        if (cmd.accept) begin
            item_mode_next = s_tuser;
            item_data_next = s_tdata;
            left_next      = 2'd2;
            acc_next       = '{default: '0};
            sum_next       = '0;
            rd_next        = '0;
            smp_next       = '0;
        end

        // register access and buffer start
        if (cmd.exec) begin
            case (item_mode_reg)
                tnsg_pkg::MODE_LATCH: begin
                    addr_next = item_data_reg[3:0];
                end
                tnsg_pkg::MODE_WRITE: begin
                    wv = item_data_reg;
                    if (addr_reg inside {4'd1, 4'd3, 4'd5, tnsg_pkg::REG_SHAPE}) begin
                        wv = wv & 8'h0f;
                    end else if (addr_reg inside {tnsg_pkg::REG_NOISE, 4'd8, 4'd9,
                                                  4'd10}) begin
                        wv = wv & 8'h1f;
                    end
                    reg_file_next[addr_reg] = wv;
                    // tone periods
                    for (int ch = 0; ch < 3; ch++) begin
                        if (addr_reg[3:1] == 3'(ch)) begin
                            fine   = addr_reg[0] ? reg_file_reg[2*ch] : wv;
                            coarse = addr_reg[0] ? wv : reg_file_reg[2*ch+1];
                            per    = tnsg_pkg::scale_period({4'h0, coarse[3:0], fine});
                            tone_period_next[ch] = per[12:0];
                            rc = tnsg_pkg::retune(
                                {{5{tone_count_reg[ch][13]}}, tone_count_reg[ch]},
                                per, {4'h0, tone_period_reg[ch]});
                            tone_count_next[ch] = rc[13:0];
                        end
                    end
                    // noise period
                    if (addr_reg == tnsg_pkg::REG_NOISE) begin
                        per = tnsg_pkg::scale_period({11'h0, wv[4:0]});
                        noise_period_next = per[5:0];
                        rc = tnsg_pkg::retune(
                            {{11{noise_count_reg[7]}}, noise_count_reg},
                            per, {11'h0, noise_period_reg});
                        noise_count_next = rc[7:0];
                    end
                    // channel volumes
                    for (int ch = 0; ch < 3; ch++) begin
                        if (addr_reg == 4'(tnsg_pkg::REG_VOL_A + 4'(ch))) begin
                            uses_env_next[ch] = wv[4];
                            chan_vol_next[ch] = wv[4] ? env_vol_reg :
                                tnsg_pkg::level((wv[4:0] == 5'd0) ? 5'd0 : {wv[3:0], 1'b1});
                        end
                    end
                    // envelope period
                    if (addr_reg == tnsg_pkg::REG_ENV_FINE ||
                        addr_reg == tnsg_pkg::REG_ENV_COARSE) begin
                        fine   = (addr_reg == tnsg_pkg::REG_ENV_FINE) ? wv :
                                 reg_file_reg[tnsg_pkg::REG_ENV_FINE];
                        coarse = (addr_reg == tnsg_pkg::REG_ENV_COARSE) ? wv :
                                 reg_file_reg[tnsg_pkg::REG_ENV_COARSE];
                        per    = tnsg_pkg::scale_period({coarse, fine});
                        env_period_next = per;
                        rc = tnsg_pkg::retune({env_count_reg[17], env_count_reg},
                                              per, env_period_reg);
                        env_count_next = rc[17:0];
                    end
                    // envelope shape restarts the envelope
                    if (addr_reg == tnsg_pkg::REG_SHAPE) begin
                        att = wv[2] ? 5'h1f : 5'h00;
                        flg = wv[3] ? {1'b0, wv[1], wv[0]} : {1'b0, wv[2], 1'b1};
                        env_attack_next = att;
                        env_flags_next  = flg;
                        env_count_next  = {1'b0, env_period_reg};
                        env_step_next   = 8'h1f;
                        vol             = tnsg_pkg::level(5'h1f ^ att);
                        env_vol_next    = vol;
                        for (int ch = 0; ch < 3; ch++) begin
                            if (uses_env_reg[ch]) begin
                                chan_vol_next[ch] = vol;
                            end
                        end
                    end
                end
                tnsg_pkg::MODE_READ: begin
                    rd_next = reg_file_reg[addr_reg];
                end
                tnsg_pkg::MODE_START: begin
                    // park disabled or silent channels
                    for (int ch = 0; ch < 3; ch++) begin
                        if (reg_file_reg[tnsg_pkg::REG_ENABLE][ch] ||
                            reg_file_reg[8+ch] == 8'd0) begin
                            if (tone_count_reg[ch] <= 14'(tnsg_pkg::PARK_LIMIT)) begin
                                tone_count_next[ch] = tone_count_reg[ch] +
                                                      14'(tnsg_pkg::PARK_LIMIT);
                            end
                            if (reg_file_reg[tnsg_pkg::REG_ENABLE][ch]) begin
                                tone_level_next[ch] = 1'b1;
                            end
                        end
                    end
                    if (reg_file_reg[tnsg_pkg::REG_ENABLE][5:3] == 3'b111 &&
                        noise_count_reg <= 8'(tnsg_pkg::PARK_LIMIT)) begin
                        noise_count_next = noise_count_reg + 8'(tnsg_pkg::PARK_LIMIT);
                    end
                    gate_mask_next = noise_level_reg | reg_file_reg[tnsg_pkg::REG_ENABLE];
                end
                default: begin
                end
            endcase
        end

        // one noise interval: three tones and the noise generator
        if (cmd.noise) begin
            for (int ch = 0; ch < 3; ch++) begin
                c       = {tone_count_reg[ch][13], tone_count_reg[ch]};
                cp      = c - (two ? 15'sd2 : 15'sd1);
                pp      = $signed({2'b00, tone_period_reg[ch]});
                negc    = -cp;
                contrib = 2'd0;
                if (cp > 15'sd0) begin
                    tone_count_next[ch] = cp[13:0];
                    if (gate_mask_reg[3+ch] && tone_level_reg[ch]) begin
                        contrib = two ? 2'd2 : 2'd1;
                    end
                end else if (cp + pp > 15'sd0) begin
                    cp = cp + pp;
                    tone_count_next[ch] = cp[13:0];
                    tone_level_next[ch] = ~tone_level_reg[ch];
                    if (gate_mask_reg[3+ch]) begin
                        contrib = tone_level_reg[ch] ? c[1:0] : negc[1:0];
                    end
                end else begin
                    // a full period passed inside the interval
                    tone_count_next[ch] = 14'sd1;
                    if (gate_mask_reg[3+ch]) begin
                        contrib = 2'd1;
                    end
                end
                acc_next[ch] = acc_reg[ch] + {1'b0, contrib};
            end
            ncp = {noise_count_reg[7], noise_count_reg} - (two ? 9'sd2 : 9'sd1);
            if (ncp <= 9'sd0) begin
                nl = noise_level_reg;
                if (lfsr_reg[0] ^ lfsr_reg[1]) begin
                    nl = ~nl;
                    gate_mask_next = nl | reg_file_reg[tnsg_pkg::REG_ENABLE];
                end
                noise_level_next = nl;
                lt = {1'b0, lfsr_reg} ^ (lfsr_reg[0] ? tnsg_pkg::LFSR_TAPS : 18'h0);
                lfsr_next = lt[17:1];
                ncp = ncp + $signed({3'b000, noise_period_reg});
            end
            noise_count_next = ncp[7:0];
            left_next = left_reg - (two ? 2'd2 : 2'd1);
        end

        // envelope step
        if (cmd.env && !env_flags_reg[2]) begin
            ec = {env_count_reg[17], env_count_reg} - 19'(tnsg_pkg::ENV_DECREMENT);
            pe = $signed({2'b00, env_period_reg});
            if (ec <= 19'sd0) begin
                st = env_step_reg;
                if (ec + pe > 19'sd0) begin
                    ec = ec + pe;
                    st = st - 8'd1;
                end else begin
                    ec = ec + pe + pe;
                    st = st - 8'd2;
                end
                att = env_attack_reg;
                flg = env_flags_reg;
                if (st[7]) begin
                    if (flg[0]) begin
                        if (flg[1]) begin
                            att = att ^ 5'h1f;
                        end
                        flg[2] = 1'b1;
                        st     = 8'd0;
                    end else begin
                        if (flg[1] && st[5]) begin
                            att = att ^ 5'h1f;
                        end
                        st = st & 8'h1f;
                    end
                end
                env_step_next   = st;
                env_attack_next = att;
                env_flags_next  = flg;
                vol             = tnsg_pkg::level(st[4:0] ^ att);
                env_vol_next    = vol;
                for (int ch = 0; ch < 3; ch++) begin
                    if (uses_env_reg[ch]) begin
                        chan_vol_next[ch] = vol;
                    end
                end
            end
            env_count_next = ec[17:0];
        end

        // mix one channel per cycle
        if (cmd.mac) begin
            prod     = 19'(acc_reg[cmd.mac_ch]) * 19'(chan_vol_reg[cmd.mac_ch]);
            sum_next = sum_reg + prod;
        end

        // scale the mixed sum to a byte
        if (cmd.scale) begin
            q = 20'(sum_reg[18:9]) * 20'(tnsg_pkg::SCALE_RECIP);
            q = q >> tnsg_pkg::SCALE_SHIFT;
            smp_next = (q > 20'd255) ? 8'hff : q[7:0];
        end

        if (cmd.sub_init) begin
            left_next = 2'd2;
            acc_next  = '{default: '0};
        end

        // result beat
        if (cmd.load_out) begin
            m_data_next = {smp_reg, rd_reg};
            m_user_next = (item_mode_reg == tnsg_pkg::MODE_TICK);
        end
    end

    // generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_file_reg     <= '{default: '0};
            addr_reg         <= '0;
            tone_period_reg  <= '{default: 13'(tnsg_pkg::PERIOD_SCALE)};
            tone_count_reg   <= '{default: 14'sd1};
            tone_level_reg   <= '0;
            noise_period_reg <= 6'(tnsg_pkg::PERIOD_SCALE);
            noise_count_reg  <= 8'sd1;
            noise_level_reg  <= 8'hff;
            gate_mask_reg    <= 8'hff;
            lfsr_reg         <= 17'd1;
            env_period_reg   <= 17'(tnsg_pkg::PERIOD_SCALE);
            env_count_reg    <= 18'sd1;
            env_step_reg     <= '0;
            env_flags_reg    <= '0;
            env_attack_reg   <= '0;
            env_vol_reg      <= '0;
            chan_vol_reg     <= '{default: '0};
            uses_env_reg     <= '0;
        end else begin
            reg_file_reg     <= reg_file_next;
            addr_reg         <= addr_next;
            tone_period_reg  <= tone_period_next;
            tone_count_reg   <= tone_count_next;
            tone_level_reg   <= tone_level_next;
            noise_period_reg <= noise_period_next;
            noise_count_reg  <= noise_count_next;
            noise_level_reg  <= noise_level_next;
            gate_mask_reg    <= gate_mask_next;
            lfsr_reg         <= lfsr_next;
            env_period_reg   <= env_period_next;
            env_count_reg    <= env_count_next;
            env_step_reg     <= env_step_next;
            env_flags_reg    <= env_flags_next;
            env_attack_reg   <= env_attack_next;
            env_vol_reg      <= env_vol_next;
            chan_vol_reg     <= chan_vol_next;
            uses_env_reg     <= uses_env_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_mode_reg <= item_mode_next;
        item_data_reg <= item_data_next;
        left_reg      <= left_next;
        acc_reg       <= acc_next;
        sum_reg       <= sum_next;
        rd_reg        <= rd_next;
        smp_reg       <= smp_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

endmodule

// ===== src/three_tone_noise_envelope_sound_gen_unit.sv =====
// top level of the three-tone sound generator with noise and envelope
// depends on tnsg_pkg, tnsg_ctrl and tnsg_dp
//
//   channel  | direction | ports                                | beat
//   ---------+-----------+--------------------------------------+---------------------------
//   request  | in        | s_tvalid s_tready s_tdata s_tuser    | one command or sample tick
//   result   | out       | m_tvalid m_tready m_tdata m_tuser    | one beat per request
//
// latch, write, read and buffer start pass through the execute and done states;
// a sample tick runs two sub-steps of one or two noise intervals and an envelope step each,
// with the three channels mixed through the shared multiplier and scaled after the first.
// reset is synchronous and returns all generator state to its power-on values.
// one request is in work at a time; the next is taken while the last result
// waits in the output register, and a stalled m_tready holds the block in its final state.
module three_tone_noise_envelope_sound_gen_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data
    input  logic [2:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_data, sample
    output logic        m_tuser    // sample_valid
);

    tnsg_pkg::cmd_t cmd;
    tnsg_pkg::sts_t sts;

    tnsg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tnsg_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
